### src/coordinate_hash_set_macros.svh
// ----------------------------------------------------------------------------
// Coordinate hash set assertion macros
// Shared property shapes for the checker of the coordinate hash set.
// ----------------------------------------------------------------------------
`ifndef COORDINATE_HASH_SET_MACROS_SVH
`define COORDINATE_HASH_SET_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define CHS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define CHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/chs_pkg.sv
// ----------------------------------------------------------------------------
// Coordinate hash set package
// Command and status codes, hash multipliers and the stored slot layout.
// ----------------------------------------------------------------------------
package chs_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic [63:0] HASH_MUL_X = 64'h114a_efbc_97f1_8777;
  localparam logic [63:0] HASH_MUL_Y = 64'h2a74_8ed2_2de1_45df;

  localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

  // One table slot as held in the slot memory.
  typedef struct packed {
    logic        valid;
    logic [63:0] x;
    logic [63:0] y;
    logic [31:0] shade;
    logic [63:0] tag;
  } slot_t;

endpackage

### src/chs_ram.sv
// ----------------------------------------------------------------------------
// Coordinate hash set RAM
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module chs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/chs_hash.sv
// ----------------------------------------------------------------------------
// Coordinate hash set hash unit
// Forms (x*K1 + y*K2) mod 2^64 from six 32x32 products, then reduces it
// modulo the table depth.
// ----------------------------------------------------------------------------
module chs_hash #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [63:0]                    coord_x,
  input  logic [63:0]                    coord_y,
  output logic                           done,
  output logic [$clog2(TABLE_DEPTH)-1:0] slot_idx
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int REM_W = IDX_W + 1;
  localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam logic [REM_W-1:0] DEPTH_R = REM_W'(TABLE_DEPTH);
  localparam logic [2:0] LAST_STEP = 3'd6;
  localparam logic [3:0] LAST_CHUNK = 4'hf;

  typedef enum logic [1:0] {
    H_IDLE,
    H_MUL,
    H_RED
  } hstate_t;

  hstate_t          state_r;
  logic [63:0]      x_r;
  logic [63:0]      y_r;
  logic [2:0]       step_r;
  logic [63:0]      prod_r;
  logic             psh_r;
  logic             pvalid_r;
  logic [63:0]      acc_r;
  logic [REM_W-1:0] rem_r;
  logic [3:0]       chunk_r;
  logic             done_r;
  logic [IDX_W-1:0] idx_r;

  logic [31:0]      op_a;
  logic [31:0]      op_b;
  logic             op_sh;
  logic [63:0]      mul_prod;
  logic [63:0]      term;
  logic [REM_W-1:0] rem_nxt;

  // Low 64 bits of a 64x64 product: lo*lo plus both cross terms moved up.
  always_comb begin
    op_a  = x_r[31:0];
    op_b  = chs_pkg::HASH_MUL_X[31:0];
    op_sh = 1'b0;
    case (step_r)
      3'd0: begin
        op_a = x_r[31:0];
        op_b = chs_pkg::HASH_MUL_X[31:0];
      end
      3'd1: begin
        op_a = x_r[63:32];
        op_b = chs_pkg::HASH_MUL_X[31:0];
      end
      3'd2: begin
        op_a = x_r[31:0];
        op_b = chs_pkg::HASH_MUL_X[63:32];
      end
      3'd3: begin
        op_a = y_r[31:0];
        op_b = chs_pkg::HASH_MUL_Y[31:0];
      end
      3'd4: begin
        op_a = y_r[63:32];
        op_b = chs_pkg::HASH_MUL_Y[31:0];
      end
      3'd5: begin
        op_a = y_r[31:0];
        op_b = chs_pkg::HASH_MUL_Y[63:32];
      end
      default: begin
        op_a = x_r[31:0];
        op_b = chs_pkg::HASH_MUL_X[31:0];
      end
    endcase
    case (step_r) inside
      3'd1, 3'd2, 3'd4, 3'd5: op_sh = 1'b1;
      default:                op_sh = 1'b0;
    endcase
  end

  assign mul_prod = 64'(op_a) * 64'(op_b);
  assign term     = psh_r ? {prod_r[31:0], 32'd0} : prod_r;

  // Four bits of restoring remainder per cycle, most significant first.
  always_comb begin
    rem_nxt = rem_r;
    for (int i = 0; i < 4; i++) begin
      rem_nxt = {rem_nxt[REM_W-2:0], acc_r[63-i]};
      if (rem_nxt >= DEPTH_R) begin
        rem_nxt = rem_nxt - DEPTH_R;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= H_IDLE;
      pvalid_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        H_IDLE: begin
          if (start) begin
            x_r      <= coord_x;
            y_r      <= coord_y;
            step_r   <= '0;
            acc_r    <= '0;
            pvalid_r <= 1'b0;
            rem_r    <= '0;
            chunk_r  <= '0;
            state_r  <= H_MUL;
          end
        end
        H_MUL: begin
          if (step_r != LAST_STEP) begin
            prod_r <= mul_prod;
            psh_r  <= op_sh;
            step_r <= step_r + 3'd1;
          end else begin
            state_r <= H_RED;
          end
          pvalid_r <= step_r != LAST_STEP;
          if (pvalid_r) begin
            acc_r <= acc_r + term;
          end
        end
        H_RED: begin
          if (IS_POW2) begin
            idx_r   <= acc_r[IDX_W-1:0];
            done_r  <= 1'b1;
            state_r <= H_IDLE;
          end else begin
            rem_r   <= rem_nxt;
            acc_r   <= {acc_r[59:0], 4'd0};
            chunk_r <= chunk_r + 4'd1;
            if (chunk_r == LAST_CHUNK) begin
              idx_r   <= rem_nxt[IDX_W-1:0];
              done_r  <= 1'b1;
              state_r <= H_IDLE;
            end
          end
        end
        default: state_r <= H_IDLE;
      endcase
    end
  end

  assign done     = done_r;
  assign slot_idx = idx_r;

endmodule

### src/coordinate_hash_set.sv
// ----------------------------------------------------------------------------
// Coordinate hash set
// Open-addressed set of (x, y) keys with linear probing, live entry count
// and bounding box of the inserted coordinates.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake           Payload
//  in_      request    in_valid/in_stall   command, coord_x, coord_y, shade, tag
//  out_     result     out_valid/out_stall status, found, found_shade,
//                                          found_tag, live_count, box
//
// A request is hashed from six 32x32 products and reduced modulo TABLE_DEPTH
// (a bit slice for a power of two, a restoring division otherwise); it then
// probes from the hashed slot one slot per clock until it stops, and reports.
// A clear, and the sweep after reset, write every slot empty, and no request
// is taken while they run. The next request is taken while a result still
// waits on out_stall; a new result waits in turn until the output register
// is free.
//
module coordinate_hash_set #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_coord_x,
  input  logic [63:0] in_coord_y,
  input  logic [31:0] in_shade,
  input  logic [63:0] in_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_found,
  output logic [31:0] out_found_shade,
  output logic [63:0] out_found_tag,
  output logic [10:0] out_live_count,
  output logic [63:0] out_least_x,
  output logic [63:0] out_greatest_x,
  output logic [63:0] out_least_y,
  output logic [63:0] out_greatest_y
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int SLOT_W = $bits(chs_pkg::slot_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_CHECK,
    S_DONE
  } state_t;

  state_t             state_r;
  logic               clear_pend_r;
  logic [IDX_W-1:0]   clr_addr_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   probes_r;
  chs_pkg::cmd_t      cmd_r;
  logic [63:0]        x_r;
  logic [63:0]        y_r;
  logic [31:0]        shade_r;
  logic [63:0]        tag_r;
  logic [CNT_W-1:0]   count_r;
  logic [63:0]        min_x_r;
  logic [63:0]        max_x_r;
  logic [63:0]        min_y_r;
  logic [63:0]        max_y_r;
  logic [1:0]         res_status_r;
  logic               res_found_r;
  logic [31:0]        res_shade_r;
  logic [63:0]        res_tag_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic               out_found_r;
  logic [31:0]        out_shade_r;
  logic [63:0]        out_tag_r;
  logic [10:0]        out_count_r;
  logic [63:0]        out_min_x_r;
  logic [63:0]        out_max_x_r;
  logic [63:0]        out_min_y_r;
  logic [63:0]        out_max_y_r;

  logic               in_accept;
  logic               hash_start;
  logic               hash_done;
  logic [IDX_W-1:0]   hash_idx;
  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;
  chs_pkg::slot_t     ram_wr_word;
  logic               ram_rd_en;
  logic [IDX_W-1:0]   ram_rd_addr;
  logic [SLOT_W-1:0]  ram_rd_data;
  chs_pkg::slot_t     rd_slot;
  logic [IDX_W-1:0]   idx_inc;
  logic               slot_empty;
  logic               slot_match;
  logic               probe_stop;
  logic               probe_last;
  logic               finish;
  logic               out_free;

  // Requests are taken only when the engine is idle; the result register
  // in front of out_ lets a finished result wait without holding this up.
  assign in_stall   = state_r != S_IDLE;
  assign in_accept  = in_valid && !in_stall;
  assign hash_start = in_accept && (chs_pkg::cmd_t'(in_command) != chs_pkg::CMD_CLEAR);
  assign out_free   = !out_valid_r || !out_stall;

  chs_hash #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (hash_start),
    .coord_x (in_coord_x),
    .coord_y (in_coord_y),
    .done    (hash_done),
    .slot_idx(hash_idx)
  );

  // Probe decision on the slot whose read data has just come back.
  assign rd_slot    = chs_pkg::slot_t'(ram_rd_data);
  assign idx_inc    = (idx_r == LAST_IDX) ? '0 : idx_r + IDX_W'(1);
  assign slot_empty = !rd_slot.valid;
  assign slot_match = rd_slot.valid && (rd_slot.x == x_r) && (rd_slot.y == y_r);
  assign probe_stop = slot_empty || slot_match;
  assign probe_last = probes_r == LAST_IDX;
  assign finish     = (state_r == S_CHECK) && (probe_stop || probe_last);

  // While probing continues the next slot is read in the same cycle, so the
  // chain advances one slot per clock. Besides the clear sweep, only the check
  // that ends a probe writes, and the next request reads nothing until its
  // hash is done, so a write and a read of the same slot never overlap.
  assign ram_rd_en   = (state_r == S_PROBE) || ((state_r == S_CHECK) && !finish);
  assign ram_rd_addr = (state_r == S_CHECK) ? idx_inc : idx_r;

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = idx_r;
    ram_wr_word = '0;
    if (state_r == S_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_addr_r;
    end else if (finish) begin
      case (cmd_r)
        chs_pkg::CMD_INSERT: begin
          ram_wr_en         = probe_stop;
          ram_wr_word.valid = 1'b1;
          ram_wr_word.x     = x_r;
          ram_wr_word.y     = y_r;
          ram_wr_word.shade = shade_r;
          ram_wr_word.tag   = tag_r;
        end
        chs_pkg::CMD_DELETE: ram_wr_en = slot_match;
        default:             ram_wr_en = 1'b0;
      endcase
    end
  end

  chs_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(TABLE_DEPTH)
  ) u_slots (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_word),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // Reset starts a sweep that empties every slot.
      state_r      <= S_CLEAR;
      clear_pend_r <= 1'b0;
      clr_addr_r   <= '0;
      count_r      <= '0;
      min_x_r      <= chs_pkg::ALL_ONES;
      max_x_r      <= '0;
      min_y_r      <= chs_pkg::ALL_ONES;
      max_y_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + IDX_W'(1);
          if (clr_addr_r == LAST_IDX) begin
            clr_addr_r <= '0;
            state_r    <= clear_pend_r ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            cmd_r        <= chs_pkg::cmd_t'(in_command);
            x_r          <= in_coord_x;
            y_r          <= in_coord_y;
            shade_r      <= in_shade;
            tag_r        <= in_tag;
            res_status_r <= chs_pkg::ST_OK;
            res_found_r  <= 1'b0;
            res_shade_r  <= '0;
            res_tag_r    <= '0;
            if (chs_pkg::cmd_t'(in_command) == chs_pkg::CMD_CLEAR) begin
              // A clear empties the table by sweeping it, then reports.
              clear_pend_r <= 1'b1;
              count_r      <= '0;
              min_x_r      <= chs_pkg::ALL_ONES;
              max_x_r      <= '0;
              min_y_r      <= chs_pkg::ALL_ONES;
              max_y_r      <= '0;
              state_r      <= S_CLEAR;
            end else begin
              state_r <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            idx_r    <= hash_idx;
            probes_r <= '0;
            state_r  <= S_PROBE;
          end
        end
        S_PROBE: begin
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (finish) begin
            state_r <= S_DONE;
            case (cmd_r)
              chs_pkg::CMD_INSERT: begin
                if (probe_stop) begin
                  if (!slot_match) begin
                    count_r <= count_r + CNT_W'(1);
                  end
                  if (x_r < min_x_r) min_x_r <= x_r;
                  if (x_r > max_x_r) max_x_r <= x_r;
                  if (y_r < min_y_r) min_y_r <= y_r;
                  if (y_r > max_y_r) max_y_r <= y_r;
                end else begin
                  // Every slot is live and none holds the key.
                  res_status_r <= chs_pkg::ST_FULL;
                end
              end
              chs_pkg::CMD_DELETE: begin
                if (slot_match) begin
                  res_found_r <= 1'b1;
                  if (count_r != '0) begin
                    count_r <= count_r - CNT_W'(1);
                  end
                end else begin
                  res_status_r <= chs_pkg::ST_ABSENT;
                end
              end
              default: begin
                if (slot_match) begin
                  res_found_r <= 1'b1;
                  res_shade_r <= rd_slot.shade;
                  res_tag_r   <= rd_slot.tag;
                end else begin
                  res_status_r <= chs_pkg::ST_ABSENT;
                end
              end
            endcase
          end else begin
            idx_r    <= idx_inc;
            probes_r <= probes_r + IDX_W'(1);
          end
        end
        S_DONE: begin
          // Hand the result over once the output register is free.
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_found_r  <= res_found_r;
            out_shade_r  <= res_shade_r;
            out_tag_r    <= res_tag_r;
            out_count_r  <= 11'(count_r);
            out_min_x_r  <= min_x_r;
            out_max_x_r  <= max_x_r;
            out_min_y_r  <= min_y_r;
            out_max_y_r  <= max_y_r;
            clear_pend_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_found_shade = out_shade_r;
  assign out_found_tag   = out_tag_r;
  assign out_live_count  = out_count_r;
  assign out_least_x     = out_min_x_r;
  assign out_greatest_x  = out_max_x_r;
  assign out_least_y     = out_min_y_r;
  assign out_greatest_y  = out_max_y_r;

endmodule

### src/chs_checker.sv
// ----------------------------------------------------------------------------
// Coordinate hash set checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "coordinate_hash_set_macros.svh"

module chs_checker #(
  parameter int TABLE_DEPTH = 1024
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic        out_found,
  input logic [31:0] out_found_shade,
  input logic [63:0] out_found_tag,
  input logic [10:0] out_live_count,
  input logic [63:0] out_least_x,
  input logic [63:0] out_greatest_x,
  input logic [63:0] out_least_y,
  input logic [63:0] out_greatest_y
);

  // A hit is always a successful request.
  `CHS_ASSERT_IMPL(a_found_ok, out_valid && out_found, out_status == chs_pkg::ST_OK, "found with non-ok status")

  // Payload of a miss is zero.
  `CHS_ASSERT_IMPL(a_miss_zero, out_valid && !out_found, (out_found_shade == 32'd0) && (out_found_tag == 64'd0), "payload on a miss")

  // A full table means every slot is live.
  `CHS_ASSERT_IMPL(a_full_count, out_valid && (out_status == chs_pkg::ST_FULL), out_live_count == 11'(TABLE_DEPTH), "full with wrong count")

  // Once anything is inserted the box is well formed.
  `CHS_ASSERT_IMPL(a_box_order, out_valid, ((out_least_x == chs_pkg::ALL_ONES) || (out_least_x <= out_greatest_x)) && ((out_least_y == chs_pkg::ALL_ONES) || (out_least_y <= out_greatest_y)), "box inverted")

  // A waiting result keeps its count, least x and greatest y.
  `CHS_ASSERT_NEXT(a_hold, out_valid && out_stall, $stable(out_live_count) && $stable(out_least_x) && $stable(out_greatest_y), "result changed while stalled")

endmodule

bind coordinate_hash_set chs_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_chs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_found      (out_found),
  .out_found_shade(out_found_shade),
  .out_found_tag  (out_found_tag),
  .out_live_count (out_live_count),
  .out_least_x    (out_least_x),
  .out_greatest_x (out_greatest_x),
  .out_least_y    (out_least_y),
  .out_greatest_y (out_greatest_y)
);
